>>> hdl/iib_pkg.sv
// ----------------------------------------------------------------------------
// iib_pkg
// shared widths, register indexes and default sizes for the integral image
// builder
// ----------------------------------------------------------------------------
package iib_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_SAMPLE_BITS  = 8;

  localparam int SUM_BITS       = 28;
  localparam int ROW_BITS       = 18;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int RESET_WIDTH    = 1024;
  localparam int RESET_HEIGHT   = 1024;
  localparam int RESET_CHANNELS = 1;

endpackage

>>> hdl/iib_in_if.sv
// ----------------------------------------------------------------------------
// iib_in_if
// sample stream channel, one channel sample per beat
// ----------------------------------------------------------------------------
interface iib_in_if #(
  parameter int SAMPLE_BITS = iib_pkg::DEF_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/iib_out_if.sv
// ----------------------------------------------------------------------------
// iib_out_if
// result channel, one summed-area value per beat
// ----------------------------------------------------------------------------
interface iib_out_if;
  logic                         valid;
  logic                         ready;
  logic [iib_pkg::SUM_BITS-1:0] area_sum;
  logic                         frame_end;

  modport source (output valid, output area_sum, output frame_end, input ready);
  modport sink   (input valid, input area_sum, input frame_end, output ready);
endinterface

>>> hdl/iib_cfg_if.sv
// ----------------------------------------------------------------------------
// iib_cfg_if
// register write channel, one register write per beat
// ----------------------------------------------------------------------------
interface iib_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [iib_pkg::CFG_INDEX_BITS-1:0] index;
  logic [iib_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/integral_image_builder.sv
// ----------------------------------------------------------------------------
// integral_image_builder
// streaming summed-area table: per-channel running row sums plus a line
// store of the previous row's integral values
// ----------------------------------------------------------------------------
// datapath: line store read in stage 1, then the sum into the result register
// throughput: 1 sample per cycle while out_ch is ready, set by one line store
// read and one write per cycle with a bypass for back-to-back hits on the same entry
// reset: positions and row sums clear, registers return to 1024 x 1024 x 1,
// line store contents are not cleared; the top row adds zero, so entries are used only once written
// ----------------------------------------------------------------------------
module integral_image_builder #(
  parameter int MAX_WIDTH    = iib_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = iib_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = iib_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = iib_pkg::DEF_SAMPLE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  iib_in_if.sink       in_ch,
  iib_out_if.source    out_ch,
  iib_cfg_if.sink      cfg_ch
);
  import iib_pkg::*;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH    = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int WID_RST  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int HGT_RST  = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
  localparam int CNT_RST  = (RESET_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : RESET_CHANNELS;

  // configuration
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [CNT_W-1:0] chan_cnt_r;
  logic             cfg_acc;
  logic [31:0]      cfg_val;
  logic [31:0]      wid_clamp;
  logic [31:0]      hgt_clamp;
  logic [31:0]      cnt_clamp;

  // stage 0 positions and row sums
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [CH_W-1:0]     ch_r;
  logic [ROW_BITS-1:0] rrs_r [MAX_CHANNELS];
  logic                in_acc;
  logic                last_ch;
  logic                last_col;
  logic                last_row;
  logic [ROW_BITS-1:0] row_sum_nxt;
  logic [ADDR_W-1:0]   idx;

  // stage 1
  logic                s1_vld_r;
  logic [ROW_BITS-1:0] s1_row_sum_r;
  logic [ADDR_W-1:0]   s1_idx_r;
  logic                s1_top_r;
  logic                s1_end_r;
  logic                s1_adv;
  logic                s1_free;
  logic [SUM_BITS-1:0] rd_data_r;
  logic [SUM_BITS-1:0] above;
  logic [SUM_BITS-1:0] total;
  logic                fwd_hit;

  // last write, for a read that meets a write to the same entry
  logic                wr_vld_r;
  logic [ADDR_W-1:0]   wr_idx_r;
  logic [SUM_BITS-1:0] wr_val_r;

  // result register
  logic                out_vld_r;
  logic [SUM_BITS-1:0] out_sum_r;
  logic                out_end_r;
  logic                out_free;

  logic [SUM_BITS-1:0] line_mem [DEPTH];

  // register writes
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign cfg_val      = 32'(cfg_ch.data);

  always_comb begin
    wid_clamp = (cfg_val == 32'd0) ? 32'd1 :
                (cfg_val > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : cfg_val;
    hgt_clamp = (cfg_val == 32'd0) ? 32'd1 :
                (cfg_val > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_val;
    cnt_clamp = (cfg_val[2:0] == 3'd0) ? 32'd1 :
                (32'(cfg_val[2:0]) > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) :
                32'(cfg_val[2:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WID_W'(WID_RST);
      height_r   <= HGT_W'(HGT_RST);
      chan_cnt_r <= CNT_W'(CNT_RST);
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:   width_r    <= WID_W'(wid_clamp);
        REG_IMAGE_HEIGHT:  height_r   <= HGT_W'(hgt_clamp);
        REG_CHANNEL_COUNT: chan_cnt_r <= CNT_W'(cnt_clamp);
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free    = !out_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && out_free;
  assign s1_free     = !s1_vld_r || s1_adv;
  assign in_ch.ready = s1_free;
  assign in_acc      = in_ch.valid && s1_free;

  // stage 0
  always_comb begin
    last_ch  = (32'(ch_r) + 32'd1) >= 32'(chan_cnt_r);
    last_col = (32'(col_r) + 32'd1) >= 32'(width_r);
    last_row = (32'(row_r) + 32'd1) >= 32'(height_r);
    row_sum_nxt = ((col_r == '0) ? '0 : rrs_r[ch_r]) +
                  ROW_BITS'(in_ch.sample[SAMPLE_BITS-1:0]);
    idx = ADDR_W'(32'(col_r) * MAX_CHANNELS + 32'(ch_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        rrs_r[i] <= '0;
      end
    end else if (in_acc) begin
      rrs_r[ch_r] <= row_sum_nxt;
      if (last_ch) begin
        ch_r <= '0;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= line_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_idx_r] <= total;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_sum_r <= row_sum_nxt;
      s1_idx_r     <= idx;
      s1_top_r     <= (row_r == '0);
      s1_end_r     <= last_ch && last_col && last_row;
    end
  end

  assign fwd_hit = wr_vld_r && (wr_idx_r == s1_idx_r);
  assign above   = s1_top_r ? '0 : (fwd_hit ? wr_val_r : rd_data_r);
  assign total   = above + SUM_BITS'(s1_row_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else if (s1_adv) begin
      wr_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wr_idx_r <= s1_idx_r;
      wr_val_r <= total;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sum_r <= total;
      out_end_r <= s1_end_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.area_sum  = out_sum_r;
  assign out_ch.frame_end = out_end_r;

  // checks
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted beat did not reach stage 1");

  a_s1_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("stage 1 advanced without filling the result register");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_r == '0) |=> s1_row_sum_r == ROW_BITS'($past(in_ch.sample)))
    else $error("row sum did not restart at column zero");

endmodule
